// ===== hdl/pumdq_pkg.sv =====
// shared types and constants of the pixel universe mapper with dirty queue
// no dependencies; used by pixel_universe_mapper_dirty_queue
package pumdq_pkg;

  localparam int unsigned IDX_W      = 14;
  localparam int unsigned COLOUR_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SENDS = 2'd2;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_FLUSH    = 1'b1;
  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_SEND    = 1'b1;

  localparam logic [6:0] MAX_POPS        = 7'd64;
  localparam logic [6:0] MAX_SENDS_RESET = 7'd34;
  localparam int unsigned SLOTS_PER_PIXEL = 3;

  typedef struct packed {
    logic                req_type;
    logic [IDX_W-1:0]    pixel_index;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } req_t;

  typedef struct packed {
    logic                kind;
    logic [6:0]          universe;
    logic [8:0]          channel;
    logic [COLOUR_W-1:0] red_scaled;
    logic [COLOUR_W-1:0] green_scaled;
    logic [COLOUR_W-1:0] blue_scaled;
    logic [7:0]          sequence_res;
    logic                last;
  } res_t;

endpackage

// ===== hdl/pumdq_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module pumdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/pixel_universe_mapper_dirty_queue.sv =====
// top level: pixel to universe mapper with deduplicated dirty universe queue
// depends on pumdq_pkg and pumdq_ram (pixel store and dirty fifo)
//
// channel   | ports                                     | handshake
// request   | start, busy, req_i                        | taken when start && !busy
// result    | res_valid_o, res_o                        | one cycle strobe, no stall
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i/data | taken when valid && ready
//
// after reset the pixel store is cleared, with busy high
// pixel write: busy through 8 colour divider steps and 1 write back
// flush: read state then a pop per universe, one fifo read per cycle; not busy if nothing to pop
// results are registered in the cycle after their state; the receiver cannot stall
// config writes are always ready
module pixel_universe_mapper_dirty_queue #(
  parameter int unsigned PIXEL_COUNT         = 16384,
  parameter int unsigned PIXELS_PER_UNIVERSE = 170,
  parameter int unsigned UNIVERSE_SLOTS      = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  pumdq_pkg::req_t                     req_i,
  output logic                                res_valid_o,
  output pumdq_pkg::res_t                     res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pumdq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pumdq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW    = $clog2(PIXEL_COUNT);
  localparam int unsigned UW    = $clog2(UNIVERSE_SLOTS);
  localparam int unsigned CW    = $clog2(UNIVERSE_SLOTS + 1);
  localparam int unsigned RW    = $clog2(PIXELS_PER_UNIVERSE + 1);
  localparam int unsigned IW    = pumdq_pkg::IDX_W;
  localparam int unsigned NW    = pumdq_pkg::COLOUR_W;
  localparam int unsigned SW    = $clog2(pumdq_pkg::COLOUR_W);
  localparam int unsigned RGB_W = 3 * NW;
  localparam int unsigned MW    = IW + 1;
  localparam int unsigned RK    = IW + $clog2(PIXELS_PER_UNIVERSE);
  localparam logic [MW-1:0] RECIP_M = MW'(((64'd1 << RK) + 64'(PIXELS_PER_UNIVERSE)
                                           - 64'd1) / 64'(PIXELS_PER_UNIVERSE));

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_WRITE, ST_FREAD, ST_FPOP
  } state_e;

  state_e                state_q;
  logic [NW-1:0]         div_cfg_q;
  logic                  track_q;
  logic [6:0]            max_sends_q;
  logic [AW-1:0]         clr_cnt_q;
  logic [UNIVERSE_SLOTS-1:0] bitmap_q;
  logic [UW-1:0]         head_q;
  logic [CW-1:0]         count_q;
  logic [7:0]            seq_q;
  logic [6:0]            limit_q;
  logic [6:0]            pops_q;
  logic [SW-1:0]         step_q;
  logic                  res_valid_q;
  pumdq_pkg::res_t       res_q;

  // datapath registers
  logic [AW-1:0]         addr_q;
  logic [RGB_W-1:0]      colour_q;
  logic [NW-1:0]         divisor_q;
  logic [IW-1:0]         idx_q;
  logic [IW-1:0]         iq_q;
  logic [RW-1:0]         irem_q;
  logic [NW-1:0]         cq_q   [3];
  logic [NW-1:0]         crem_q [3];

  logic [NW-1:0]         cq_nxt   [3];
  logic [NW-1:0]         crem_nxt [3];

  logic [IW+MW-1:0]      recip_prod;
  logic [IW-1:0]         quot;
  logic [IW-1:0]         rem_full;

  logic                  accept;
  logic                  accept_write;
  logic                  idx_ok;
  logic [6:0]            limit_in;

  logic                  pix_we;
  logic [AW-1:0]         pix_waddr;
  logic [RGB_W-1:0]      pix_wdata;
  logic [RGB_W-1:0]      pix_rdata;

  logic                  fifo_we;
  logic                  fifo_re;
  logic [UW-1:0]         fifo_raddr;
  logic [UW-1:0]         fifo_rdata;
  logic [UW-1:0]         head_inc;
  logic [CW:0]           tail_sum;
  logic [UW-1:0]         tail;

  logic [IW:0]           uni;
  logic [UW-1:0]         uni_slot;
  logic                  do_queue;
  logic                  pop_last;
  logic [8:0]            chan;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign accept       = start && !busy;
  assign idx_ok       = (32'(req_i.pixel_index) < PIXEL_COUNT);
  assign accept_write = accept && (req_i.req_type == pumdq_pkg::REQ_WRITE) && idx_ok;
  assign limit_in     = (max_sends_q > pumdq_pkg::MAX_POPS) ? pumdq_pkg::MAX_POPS
                                                            : max_sends_q;

  // fifo pointers
  assign head_inc = (32'(head_q) == UNIVERSE_SLOTS - 1) ? '0 : head_q + 1'b1;
  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign tail     = (32'(tail_sum) >= UNIVERSE_SLOTS)
                    ? UW'(32'(tail_sum) - UNIVERSE_SLOTS) : UW'(tail_sum);
  assign fifo_raddr = (state_q == ST_FPOP) ? head_inc : head_q;
  assign fifo_re    = (state_q == ST_FREAD) || (state_q == ST_FPOP);
  assign pop_last   = (pops_q + 7'd1 == limit_q) || (count_q == CW'(1));

  // index split by reciprocal multiply, remainder taken from the registered quotient
  assign recip_prod = (IW+MW)'(idx_q) * (IW+MW)'(RECIP_M);
  assign quot       = IW'(recip_prod >> RK);
  assign rem_full   = idx_q - IW'(32'(iq_q) * PIXELS_PER_UNIVERSE);

  // write completion
  assign uni      = (IW+1)'(iq_q) + (IW+1)'(1);
  assign uni_slot = UW'(uni);
  assign chan     = 9'(32'(irem_q) * pumdq_pkg::SLOTS_PER_PIXEL + 1);
  assign do_queue = (state_q == ST_WRITE) && (pix_rdata != colour_q) && track_q
                    && (32'(uni) < UNIVERSE_SLOTS) && !bitmap_q[uni_slot]
                    && (32'(count_q) < UNIVERSE_SLOTS);
  assign fifo_we  = do_queue;

  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = addr_q;
    pix_wdata = colour_q;
    if (state_q == ST_CLEAR) begin
      pix_we    = 1'b1;
      pix_waddr = clr_cnt_q;
      pix_wdata = '0;
    end else if (state_q == ST_WRITE) begin
      pix_we = 1'b1;
    end
  end

  // one restoring division step per cycle
  always_comb begin
    logic [NW:0] ct;
    for (int i = 0; i < 3; i++) begin
      ct          = {crem_q[i], cq_q[i][NW-1]};
      cq_nxt[i]   = {cq_q[i][NW-2:0], 1'b0};
      crem_nxt[i] = NW'(ct);
      if (ct >= {1'b0, divisor_q}) begin
        crem_nxt[i]  = NW'(ct - {1'b0, divisor_q});
        cq_nxt[i][0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_write) begin
      addr_q    <= AW'(req_i.pixel_index);
      colour_q  <= {req_i.red, req_i.green, req_i.blue};
      divisor_q <= (div_cfg_q == '0) ? NW'(1) : div_cfg_q;
      idx_q     <= req_i.pixel_index;
      cq_q[0]   <= req_i.red;
      cq_q[1]   <= req_i.green;
      cq_q[2]   <= req_i.blue;
      for (int i = 0; i < 3; i++) begin
        crem_q[i] <= '0;
      end
    end else if (state_q == ST_DIV) begin
      if (step_q == '0) begin
        iq_q <= quot;
      end
      if (step_q == SW'(1)) begin
        irem_q <= RW'(rem_full);
      end
      for (int i = 0; i < 3; i++) begin
        cq_q[i]   <= cq_nxt[i];
        crem_q[i] <= crem_nxt[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      div_cfg_q   <= NW'(1);
      track_q     <= 1'b1;
      max_sends_q <= pumdq_pkg::MAX_SENDS_RESET;
      clr_cnt_q   <= '0;
      bitmap_q    <= '0;
      head_q      <= '0;
      count_q     <= '0;
      seq_q       <= '0;
      limit_q     <= '0;
      pops_q      <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pumdq_pkg::CFG_DIVISOR:   div_cfg_q   <= cfg_data_i;
          pumdq_pkg::CFG_TRACK:     track_q     <= cfg_data_i[0];
          pumdq_pkg::CFG_MAX_SENDS: max_sends_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(PIXEL_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept_write) begin
            step_q  <= '0;
            state_q <= ST_DIV;
          end else if (accept && (req_i.req_type == pumdq_pkg::REQ_FLUSH)) begin
            limit_q <= limit_in;
            pops_q  <= '0;
            if (limit_in != '0 && count_q != '0) begin
              state_q <= ST_FREAD;
            end
          end
        end
        ST_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == SW'(NW - 1)) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (do_queue) begin
            bitmap_q[uni_slot] <= 1'b1;
            count_q            <= count_q + 1'b1;
          end
          res_valid_q        <= 1'b1;
          res_q.kind         <= pumdq_pkg::KIND_CHANNEL;
          res_q.universe     <= 7'(uni);
          res_q.channel      <= chan;
          res_q.red_scaled   <= cq_q[0];
          res_q.green_scaled <= cq_q[1];
          res_q.blue_scaled  <= cq_q[2];
          res_q.sequence_res <= '0;
          res_q.last         <= 1'b1;
          state_q            <= ST_IDLE;
        end
        ST_FREAD: begin
          state_q <= ST_FPOP;
        end
        ST_FPOP: begin
          bitmap_q[fifo_rdata] <= 1'b0;
          head_q               <= head_inc;
          count_q              <= count_q - 1'b1;
          seq_q                <= seq_q + 1'b1;
          pops_q               <= pops_q + 1'b1;
          res_valid_q          <= 1'b1;
          res_q.kind           <= pumdq_pkg::KIND_SEND;
          res_q.universe       <= 7'(fifo_rdata);
          res_q.channel        <= '0;
          res_q.red_scaled     <= '0;
          res_q.green_scaled   <= '0;
          res_q.blue_scaled    <= '0;
          res_q.sequence_res   <= seq_q;
          res_q.last           <= pop_last;
          if (pop_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  pumdq_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PIXEL_COUNT)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .re_i    (accept_write),
    .raddr_i (AW'(req_i.pixel_index)),
    .rdata_o (pix_rdata)
  );

  pumdq_ram #(
    .WIDTH (UW),
    .DEPTH (UNIVERSE_SLOTS)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail),
    .wdata_i (uni_slot),
    .re_i    (fifo_re),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= UNIVERSE_SLOTS)
    else $error("fifo count above slot count");

  a_bitmap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(bitmap_q) == 32'(count_q))
    else $error("dirty bitmap out of step with fifo count");

  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pops_q <= pumdq_pkg::MAX_POPS)
    else $error("too many pops in one flush");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FPOP) |=> (res_valid_q && (res_q.kind == pumdq_pkg::KIND_SEND)
                              && (seq_q == res_q.sequence_res + 8'd1)))
    else $error("pop without matching send result");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !res_valid_q)
    else $error("result during clearing pass");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for pixel_universe_mapper_dirty_queue: pixel writes, flushes and
// register writes, each result compared field by field with a behavioral mapper model
// depends on pumdq_pkg and the mapper rtl
module testbench;

  localparam int PERIOD_NS     = 4;
  localparam int LIMIT_NS      = 2_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int unsigned PIXELS     = 16384;
  localparam int unsigned UNI_PIXELS = 170;
  localparam int unsigned UNI_SLOTS  = 128;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  pumdq_pkg::req_t                  req_i;
  logic                             res_valid_o;
  pumdq_pkg::res_t                  res_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [pumdq_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [pumdq_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // model of the pixel store, dirty queue and registers
  logic [23:0]  pixel_mem [PIXELS];
  logic         dirty_map [UNI_SLOTS];
  logic [6:0]   dirty_ring [UNI_SLOTS];
  int unsigned  ring_count;
  int unsigned  ring_head;
  logic [7:0]   seq_ctr;
  logic [7:0]   cfg_divisor;
  logic         cfg_track;
  logic [6:0]   cfg_max_sends;

  pumdq_pkg::req_t pending_reqs [$];
  pumdq_pkg::res_t due_packets [$];
  int unsigned  errors;
  logic         req_taken;
  int unsigned  burst_left;
  int unsigned  gap_left;
  logic         bursty;

  pixel_universe_mapper_dirty_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(PERIOD_NS / 2) clk_i = ~clk_i;

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic map_request(input pumdq_pkg::req_t rq);
    int unsigned idx;
    int unsigned uni;
    int unsigned pops;
    logic [23:0] colour;
    logic [7:0]  div;
    pumdq_pkg::res_t pkt;
    if (rq.req_type == pumdq_pkg::REQ_WRITE) begin
      idx    = rq.pixel_index;
      colour = {rq.red, rq.green, rq.blue};
      uni    = idx / UNI_PIXELS + 1;
      if (pixel_mem[idx] != colour && cfg_track && uni < UNI_SLOTS && !dirty_map[uni]
          && ring_count < UNI_SLOTS) begin
        dirty_ring[(ring_head + ring_count) % UNI_SLOTS] = uni[6:0];
        ring_count++;
        dirty_map[uni] = 1'b1;
      end
      pixel_mem[idx] = colour;
      div = (cfg_divisor == 8'd0) ? 8'd1 : cfg_divisor;
      pkt              = '0;
      pkt.kind         = pumdq_pkg::KIND_CHANNEL;
      pkt.universe     = uni[6:0];
      pkt.channel      = 9'((idx % UNI_PIXELS) * pumdq_pkg::SLOTS_PER_PIXEL + 1);
      pkt.red_scaled   = rq.red / div;
      pkt.green_scaled = rq.green / div;
      pkt.blue_scaled  = rq.blue / div;
      pkt.last         = 1'b1;
      due_packets = {due_packets, pkt};
    end else begin
      pops = (cfg_max_sends > pumdq_pkg::MAX_POPS) ? pumdq_pkg::MAX_POPS : cfg_max_sends;
      if (pops > ring_count) pops = ring_count;
      for (int unsigned i = 0; i < pops; i++) begin
        pkt              = '0;
        pkt.kind         = pumdq_pkg::KIND_SEND;
        pkt.universe     = dirty_ring[ring_head];
        pkt.sequence_res = seq_ctr;
        pkt.last         = (i == pops - 1);
        dirty_map[dirty_ring[ring_head]] = 1'b0;
        ring_head = (ring_head + 1) % UNI_SLOTS;
        ring_count--;
        seq_ctr++;
        due_packets = {due_packets, pkt};
      end
    end
  endtask

  task automatic check_packet(input pumdq_pkg::res_t got, input pumdq_pkg::res_t want);
    string       names [8] = '{"kind", "universe", "channel", "red_scaled", "green_scaled",
                               "blue_scaled", "sequence_res", "last"};
    int unsigned g [8];
    int unsigned w [8];
    g = '{got.kind, got.universe, got.channel, got.red_scaled, got.green_scaled,
          got.blue_scaled, got.sequence_res, got.last};
    w = '{want.kind, want.universe, want.channel, want.red_scaled, want.green_scaled,
          want.blue_scaled, want.sequence_res, want.last};
    for (int i = 0; i < 8; i++) begin
      if (g[i] != w[i]) begin
        report_error($sformatf("%s got %0d expected %0d", names[i], g[i], w[i]));
      end
    end
  endtask

  // monitor: check results, then model any request taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        if (due_packets.size() == 0) begin
          report_error($sformatf("unexpected result universe %0d", res_o.universe));
        end else begin
          check_packet(res_o, due_packets.pop_front());
        end
      end
      req_taken = start && !busy;
      if (req_taken) map_request(req_i);
    end
  end

  // driver: requests back to back, or in bursts with random gaps when bursty is set
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        start <= 1'b1;
        req_i <= pending_reqs.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else if (bursty) begin
          burst_left = $urandom_range(0, 6);
          gap_left   = $urandom_range(1, 24);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic [23:0] pick_colour();
    logic [23:0] palette [3] = '{24'h000000, 24'hffffff, 24'h102030};
    if ($urandom_range(0, 1)) return palette[$urandom_range(0, 2)];
    return 24'($urandom);
  endfunction

  function automatic void add_write(input int unsigned idx, input logic [23:0] colour);
    pumdq_pkg::req_t rq;
    rq.req_type    = pumdq_pkg::REQ_WRITE;
    rq.pixel_index = idx[pumdq_pkg::IDX_W-1:0];
    {rq.red, rq.green, rq.blue} = colour;
    pending_reqs = {pending_reqs, rq};
  endfunction

  function automatic void add_flush();
    pumdq_pkg::req_t rq;
    rq.req_type    = pumdq_pkg::REQ_FLUSH;
    rq.pixel_index = pumdq_pkg::IDX_W'($urandom);
    {rq.red, rq.green, rq.blue} = 24'($urandom);
    pending_reqs = {pending_reqs, rq};
  endfunction

  function automatic void add_random_write();
    int unsigned hot [8] = '{0, 1, 169, 170, 339, 340, 8000, 16383};
    if ($urandom_range(0, 1)) add_write(hot[$urandom_range(0, 7)], pick_colour());
    else add_write($urandom_range(0, PIXELS - 1), pick_colour());
  endfunction

  task automatic write_reg(input logic [pumdq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pumdq_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pumdq_pkg::CFG_DIVISOR:   cfg_divisor = data;
      pumdq_pkg::CFG_TRACK:     cfg_track = data[0];
      pumdq_pkg::CFG_MAX_SENDS: cfg_max_sends = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start || due_packets.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) add_flush();
      else add_random_write();
    end
    add_flush();
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    errors        = 0;
    req_taken     = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    bursty        = 1'b1;
    cfg_divisor   = 8'd1;
    cfg_track     = 1'b1;
    cfg_max_sends = pumdq_pkg::MAX_SENDS_RESET;
    ring_count    = 0;
    ring_head     = 0;
    seq_ctr       = '0;
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    foreach (dirty_map[i]) dirty_map[i] = 1'b0;
    foreach (dirty_ring[i]) dirty_ring[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // default registers: boundaries, unchanged colour, dedup, empty flush
    add_write(0, 24'hffffff);
    add_write(16383, 24'h000000);
    add_write(169, 24'h010203);
    add_write(170, 24'h804020);
    add_write(171, 24'haa5501);
    add_write(0, 24'hffffff);
    add_write(16383, 24'h123456);
    add_flush();
    add_flush();
    settle();

    // divisor zero passes bytes, one send per flush
    write_reg(pumdq_pkg::CFG_DIVISOR, 8'd0);
    write_reg(pumdq_pkg::CFG_MAX_SENDS, 8'd1);
    bursty = 1'b0;
    add_write(1, 24'hff807f);
    add_write(340, 24'h010203);
    add_write(510, 24'h102030);
    add_flush();
    add_flush();
    add_flush();
    settle();

    // divisor max, send limit zero
    write_reg(pumdq_pkg::CFG_DIVISOR, 8'hff);
    write_reg(pumdq_pkg::CFG_MAX_SENDS, 8'd0);
    bursty = 1'b1;
    add_write(2, 24'hfffe01);
    add_write(700, 24'h7f80ff);
    add_flush();
    settle();

    // limit above the clamp
    write_reg(pumdq_pkg::CFG_MAX_SENDS, 8'hff);
    add_flush();
    add_flush();
    settle();

    // tracking off keeps what is already queued
    add_write(3, 24'h112233);
    settle();
    write_reg(pumdq_pkg::CFG_TRACK, 8'h00);
    add_write(4000, 24'h445566);
    add_write(3, 24'h998877);
    add_flush();
    add_flush();
    settle();
    write_reg(pumdq_pkg::CFG_TRACK, 8'hff);

    // one write in each of 66 universes, then flushes with the largest send limit
    write_reg(pumdq_pkg::CFG_DIVISOR, 8'd3);
    write_reg(pumdq_pkg::CFG_MAX_SENDS, 8'd64);
    for (int unsigned u = 0; u < 66; u++) begin
      add_write(u * UNI_PIXELS + $urandom_range(0, UNI_PIXELS - 1), 24'($urandom));
    end
    add_flush();
    add_flush();
    settle();

    write_reg(pumdq_pkg::CFG_DIVISOR, 8'($urandom_range(1, 255)));
    write_reg(pumdq_pkg::CFG_MAX_SENDS, 8'($urandom_range(1, 64)));
    random_phase(4);

    write_reg(pumdq_pkg::CFG_DIVISOR, 8'd2);
    write_reg(pumdq_pkg::CFG_MAX_SENDS, 8'd2);
    bursty = 1'b0;
    random_phase(4);

    write_reg(pumdq_pkg::CFG_TRACK, 8'h00);
    bursty = 1'b1;
    random_phase(2);

    write_reg(pumdq_pkg::CFG_TRACK, 8'h01);
    write_reg(pumdq_pkg::CFG_DIVISOR, 8'($urandom_range(0, 255)));
    write_reg(pumdq_pkg::CFG_MAX_SENDS, 8'($urandom_range(0, 127)));
    random_phase(4);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
